// ===== rtl/hpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

    localparam int HEAP_DEPTH  = 64;
    localparam int KEY_BITS    = 32;
    localparam int ADDR_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
    localparam int FIELD_W     = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic {
        FUNC_INSERT  = 1'b0,
        FUNC_EXTRACT = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [FIELD_W-1:0] item_key;
        logic [FIELD_W-1:0] item_payload;
    } t_req;

    typedef struct packed {
        t_status                status;
        logic [FIELD_W-1:0]     top_key;
        logic [FIELD_W-1:0]     top_payload;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [FIELD_W-1:0]  payload;
    } t_entry;

    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_top;
        logic    cap_moving;
        logic    cap_left;
        logic    step_up;
        logic    step_dn;
        logic    wr_moving;
        logic    rsp_load;
        logic    rsp_top;
        t_status rsp_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic last_zero;
        logic pos_zero;
        logic up_above;
        logic l_valid;
        logic r_valid;
        logic dn_move;
    } t_sts;

    // true when key a ranks strictly above key b
    function automatic logic ranks_above(input logic [KEY_BITS-1:0] a,
                                         input logic [KEY_BITS-1:0] b,
                                         input logic                smallest_first);
        ranks_above = smallest_first ? (a < b) : (a > b);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hpq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hpq_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hpq_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  hpq_pkg::t_cmd i_cmd,
    output hpq_pkg::t_sts o_sts,
    output logic          o_rsp_valid,
    output hpq_pkg::t_rsp o_rsp
);
    import hpq_pkg::*;

    // heap storage, one write and one registered read per cycle
    t_entry r_mem [HEAP_DEPTH];
    t_entry r_rdata;

    logic             r_smallest_first;
    logic [CNT_W-1:0] r_count;
    logic [ADDR_W-1:0] r_pos;
    t_entry           r_moving;
    t_entry           r_top;
    t_entry           r_cand;
    logic [ADDR_W-1:0] r_cidx;
    logic             r_cidx_is_pos;
    logic             r_rsp_valid;
    t_rsp             r_rsp;

    logic [CNT_W:0]    w_left;
    logic [CNT_W:0]    w_right;
    logic [ADDR_W-1:0] w_parent;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_r_ok;
    logic              w_wr_en;
    t_entry            w_wr_data;
    t_entry            w_top;
    logic              w_full;
    logic              w_empty;

    assign w_left   = (CNT_W + 1)'({r_pos, 1'b1});
    assign w_right  = (CNT_W + 1)'({r_pos, 1'b0}) + (CNT_W + 1)'(2);
    assign w_parent = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);
    assign w_full   = (r_count >= CNT_W'(HEAP_DEPTH));
    assign w_empty  = (r_count == '0);

    // root still on the read data when the extract empties the heap
    assign w_top = i_cmd.cap_top ? r_rdata : r_top;

    // right child beats the best found so far
    assign w_r_ok = o_sts.r_valid &&
                    ranks_above(r_rdata.key, r_cand.key, r_smallest_first);

    assign o_sts.full      = w_full;
    assign o_sts.empty     = w_empty;
    assign o_sts.last_zero = w_empty;
    assign o_sts.pos_zero  = (r_pos == '0);
    assign o_sts.up_above  = ranks_above(r_moving.key, r_rdata.key, r_smallest_first);
    assign o_sts.l_valid   = (w_left < {1'b0, r_count});
    assign o_sts.r_valid   = (w_right < {1'b0, r_count});
    assign o_sts.dn_move   = w_r_ok || !r_cidx_is_pos;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ROOT:   w_rd_addr = '0;
            RD_LAST:   w_rd_addr = r_count[ADDR_W-1:0];
            RD_PARENT: w_rd_addr = w_parent;
            RD_LEFT:   w_rd_addr = w_left[ADDR_W-1:0];
            RD_RIGHT:  w_rd_addr = w_right[ADDR_W-1:0];
            default:   w_rd_addr = '0;
        endcase
    end

    assign w_wr_en = i_cmd.step_up || i_cmd.step_dn || i_cmd.wr_moving;

    always_comb begin
        if (i_cmd.wr_moving) begin
            w_wr_data = r_moving;
        end else if (i_cmd.step_up) begin
            w_wr_data = r_rdata;
        end else begin
            w_wr_data = w_r_ok ? r_rdata : r_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smallest_first <= 1'b0;
            r_count          <= '0;
            r_rsp_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_smallest_first <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (i_req.func == FUNC_INSERT && !w_full) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (i_req.func == FUNC_EXTRACT && !w_empty) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
            r_rsp_valid <= i_cmd.rsp_load;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_moving.key     <= i_req.item_key[KEY_BITS-1:0];
            r_moving.payload <= i_req.item_payload;
            r_pos            <= r_count[ADDR_W-1:0];
        end
        if (i_cmd.cap_top) begin
            r_top <= r_rdata;
        end
        if (i_cmd.cap_moving) begin
            r_moving <= r_rdata;
            r_pos    <= '0;
        end
        if (i_cmd.cap_left) begin
            if (ranks_above(r_rdata.key, r_moving.key, r_smallest_first)) begin
                r_cand        <= r_rdata;
                r_cidx        <= w_left[ADDR_W-1:0];
                r_cidx_is_pos <= 1'b0;
            end else begin
                r_cand        <= r_moving;
                r_cidx        <= r_pos;
                r_cidx_is_pos <= 1'b1;
            end
        end
        if (i_cmd.step_up) begin
            r_pos <= w_parent;
        end
        if (i_cmd.step_dn) begin
            r_pos <= w_r_ok ? w_right[ADDR_W-1:0] : r_cidx;
        end
        if (i_cmd.rsp_load) begin
            r_rsp.status      <= i_cmd.rsp_status;
            r_rsp.top_key     <= i_cmd.rsp_top ? FIELD_W'(w_top.key) : '0;
            r_rsp.top_payload <= i_cmd.rsp_top ? w_top.payload : '0;
            r_rsp.entry_count <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/hpq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  hpq_pkg::t_func i_func,
    input  hpq_pkg::t_sts i_sts,
    output hpq_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import hpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_EXT_ROOT,
        S_EXT_LAST,
        S_EXT_LOAD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsp_status = ST_OK;
        o_cmd.rd_sel     = RD_ROOT;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_func == FUNC_INSERT) begin
                        if (i_sts.full) begin
                            o_cmd.rsp_load   = 1'b1;
                            o_cmd.rsp_status = ST_FULL;
                        end else begin
                            n_state = S_UP;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            o_cmd.rsp_load   = 1'b1;
                            o_cmd.rsp_status = ST_EMPTY;
                        end else begin
                            n_state = S_EXT_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                if (i_sts.pos_zero) begin
                    o_cmd.wr_moving = 1'b1;
                    o_cmd.rsp_load  = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PARENT;
                    n_state      = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_above) begin
                    o_cmd.step_up = 1'b1;
                    n_state       = S_UP;
                end else begin
                    o_cmd.wr_moving = 1'b1;
                    o_cmd.rsp_load  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EXT_ROOT: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_ROOT;
                n_state      = S_EXT_LAST;
            end
            S_EXT_LAST: begin
                o_cmd.cap_top = 1'b1;
                if (i_sts.last_zero) begin
                    o_cmd.rsp_load = 1'b1;
                    o_cmd.rsp_top  = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                    n_state      = S_EXT_LOAD;
                end
            end
            S_EXT_LOAD: begin
                o_cmd.cap_moving = 1'b1;
                n_state          = S_DN_L;
            end
            S_DN_L: begin
                if (i_sts.l_valid) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LEFT;
                    n_state      = S_DN_R;
                end else begin
                    o_cmd.wr_moving = 1'b1;
                    o_cmd.rsp_load  = 1'b1;
                    o_cmd.rsp_top   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DN_R: begin
                o_cmd.cap_left = 1'b1;
                o_cmd.rd_en    = i_sts.r_valid;
                o_cmd.rd_sel   = RD_RIGHT;
                n_state        = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_sts.dn_move) begin
                    o_cmd.step_dn = 1'b1;
                    n_state       = S_DN_L;
                end else begin
                    o_cmd.wr_moving = 1'b1;
                    o_cmd.rsp_load  = 1'b1;
                    o_cmd.rsp_top   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/binary_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// binary heap priority queue of (key, payload) entries, 64 entries deep
//
// request channel: a request is taken on a rising edge with start high and
// busy low; i_req.func picks insert or extract of the top entry
// response channel: one response per request, shown for exactly one cycle
// with o_rsp_valid high; it cannot be held off, so take it when it shows
// config: i_cfg_we writes i_cfg_wdata (smallest first); the user must write it
// only while idle, which the block does not enforce; entries already held keep
// their order, later requests compare the new way
// timing: a full-heap insert or an empty-heap extract answers the cycle after
// the request and leaves busy low. an insert reads the parent and compares at
// each level climbed, then writes the entry in place. an extract reads the root
// and the last entry, then at each level sifted down reads the left and right
// child and compares; an extract that empties the heap answers from the root
// the heap memory has a single read port with registered read data, so its
// reads are issued one at a time
// reset: the heap is emptied at once (fill count cleared), no clearing pass;
// min/max select returns to largest first
// a new request may be taken in the cycle its predecessor's response shows

module binary_heap_priority_queue_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hpq_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    output logic          o_rsp_valid,
    output hpq_pkg::t_rsp o_rsp
);
    import hpq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: insert sift-up and extract sift-down steps
    hpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_req.func),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // heap memory, fill count, moving entry, compare and response register
    hpq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/hpq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hpq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_rsp_valid,
    input hpq_pkg::t_rsp o_rsp
);
    import hpq_pkg::*;

    // an accepted request is either working or answered next cycle
    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_rsp_valid)
        else $error("request neither busy nor answered");

    // back-to-back responses only when a request was taken in between
    a_no_extra_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid ##1 o_rsp_valid |-> $past(start && !busy))
        else $error("response without request");

    // failed requests carry no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_OK |->
            o_rsp.top_key == '0 && o_rsp.top_payload == '0)
        else $error("failed request returned data");

    // empty heap reports zero entries, full heap reports depth
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |->
            (o_rsp.status != ST_EMPTY || o_rsp.entry_count == '0) &&
            (o_rsp.status != ST_FULL ||
             o_rsp.entry_count == COUNT_OUT_W'(HEAP_DEPTH)))
        else $error("entry count disagrees with status");

endmodule

bind binary_heap_priority_queue_top hpq_checker u_hpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

`default_nettype wire

// ===== test/tb_binary_heap_priority_queue_top.sv =====
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue_top;
    import hpq_pkg::*;

    localparam int TARGET_REQUESTS = 550;
    localparam int MAX_REPORTS     = 10;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  i_cfg_we;
    logic  i_cfg_wdata;
    logic  o_rsp_valid;
    t_rsp  o_rsp;

    binary_heap_priority_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    // own copy of the heap, its fill count and the ordering bit
    t_entry      heap_model [HEAP_DEPTH];
    int unsigned held;
    bit          min_first;

    t_rsp pending_rsp [$];

    bit steady;          // no idle gaps while set
    int requests_sent;
    int responses_checked;
    int mismatches;
    int n_insert, n_extract, n_full, n_empty, order_writes, max_held;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // stops the run if the block hangs
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit outranks(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
        return min_first ? (a < b) : (a > b);
    endfunction

    // applies one request to the heap copy and returns the response it gives
    function automatic t_rsp apply_request(input t_req req);
        t_rsp   r;
        t_entry tmp;
        int     pos, par, lc, rc, best;
        bit     moving;
        r = '0;
        r.status = ST_OK;
        if (req.func == FUNC_INSERT) begin
            if (held >= HEAP_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = held;
                heap_model[pos].key     = req.item_key[KEY_BITS-1:0];
                heap_model[pos].payload = req.item_payload;
                moving = 1'b1;
                // climb while strictly above the parent
                while (moving && pos > 0) begin
                    par = (pos - 1) / 2;
                    if (outranks(heap_model[pos].key, heap_model[par].key)) begin
                        tmp             = heap_model[par];
                        heap_model[par] = heap_model[pos];
                        heap_model[pos] = tmp;
                        pos             = par;
                    end else begin
                        moving = 1'b0;
                    end
                end
                held++;
            end
        end else begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.top_key     = heap_model[0].key;
                r.top_payload = heap_model[0].payload;
                held--;
                if (held > 0) begin
                    heap_model[0] = heap_model[held];
                    pos    = 0;
                    moving = 1'b1;
                    // sift down: left child first, right only if it beats that pick
                    while (moving) begin
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        best = pos;
                        if (lc < held && outranks(heap_model[lc].key, heap_model[pos].key))
                            best = lc;
                        if (rc < held && outranks(heap_model[rc].key, heap_model[best].key))
                            best = rc;
                        if (best == pos) begin
                            moving = 1'b0;
                        end else begin
                            tmp              = heap_model[best];
                            heap_model[best] = heap_model[pos];
                            heap_model[pos]  = tmp;
                            pos              = best;
                        end
                    end
                end
            end
        end
        r.entry_count = COUNT_OUT_W'(held);
        return r;
    endfunction

    // drives one request and holds it until the block takes it
    task automatic send_request(input t_func f, input logic [31:0] k,
                                input logic [31:0] p);
        t_req req;
        t_rsp want;
        int   gap;
        req.func         = f;
        req.item_key     = k;
        req.item_payload = p;
        if (!steady && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = apply_request(req);
        pending_rsp.push_back(want);
        requests_sent++;
        if (f == FUNC_INSERT) n_insert++;
        else n_extract++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        if (held > max_held) max_held = held;
    endtask

    // sender pauses until every pending response has shown
    task automatic wait_all_responses;
        start <= 1'b0;
        do @(posedge i_clk); while (pending_rsp.size() != 0 || busy !== 1'b0);
    endtask

    // only called with the block idle
    task automatic set_order(input bit smallest);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= smallest;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        min_first = smallest;
        order_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 7);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return $urandom_range(0, 15);
                    default: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
                endcase
            end
        endcase
    endfunction

    // response checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n === 1'b1 && o_rsp_valid === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $write("%0t: response with no request pending: ", $realtime);
                    $display("status %0d key %h payload %h count %0d",
                             o_rsp.status, o_rsp.top_key, o_rsp.top_payload,
                             o_rsp.entry_count);
                end
            end else begin
                want = pending_rsp.pop_front();
                responses_checked++;
                if (o_rsp.status !== want.status || o_rsp.top_key !== want.top_key ||
                    o_rsp.top_payload !== want.top_payload ||
                    o_rsp.entry_count !== want.entry_count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $write("%0t: mismatch exp status %0d key %h payload %h count %0d",
                               $realtime, want.status, want.top_key, want.top_payload,
                               want.entry_count);
                        $display(", got status %0d key %h payload %h count %0d",
                                 o_rsp.status, o_rsp.top_key, o_rsp.top_payload,
                                 o_rsp.entry_count);
                    end
                end
            end
        end
    end

    // extract from an empty heap, on both sides of a single entry
    task automatic test_empty_heap;
        send_request(FUNC_EXTRACT, 32'h1234_5678, 32'h9ABC_DEF0);
        send_request(FUNC_EXTRACT, 32'h0, 32'h0);
        send_request(FUNC_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(FUNC_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_EXTRACT, 32'h0, 32'h0);
    endtask

    // smallest, largest and mid-range keys with all-zero and all-one payloads
    task automatic test_key_extremes;
        send_request(FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FUNC_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        repeat (4) send_request(FUNC_EXTRACT, 32'h0, 32'h0);
    endtask

    // equal keys stop the climb, so payloads show the tie order
    task automatic test_equal_keys;
        send_request(FUNC_INSERT, 32'd5, 32'h0000_0001);
        send_request(FUNC_INSERT, 32'd5, 32'h0000_0002);
        send_request(FUNC_INSERT, 32'd5, 32'h0000_0003);
        send_request(FUNC_INSERT, 32'd5, 32'h0000_0004);
        repeat (4) send_request(FUNC_EXTRACT, 32'h0, 32'h0);
    endtask

    // flip the order with entries held; the old layout is not rebuilt
    task automatic test_order_switch;
        send_request(FUNC_INSERT, 32'd10, 32'hAAAA_0010);
        send_request(FUNC_INSERT, 32'd30, 32'hAAAA_0030);
        send_request(FUNC_INSERT, 32'd20, 32'hAAAA_0020);
        wait_all_responses();
        set_order(1'b1);
        send_request(FUNC_INSERT, 32'd1, 32'hBBBB_0001);
        repeat (4) send_request(FUNC_EXTRACT, 32'h0, 32'h0);
        wait_all_responses();
        set_order(1'b0);
    endtask

    // fill to capacity without idle gaps, overflow, then drain past empty
    task automatic test_full_heap;
        int i;
        set_order(1'b1);
        steady = 1'b1;
        for (i = 0; i < HEAP_DEPTH; i++)
            send_request(FUNC_INSERT, pick_key(i % 3), $urandom);
        // would become the new top if taken
        send_request(FUNC_INSERT, 32'h0000_0000, 32'hDEAD_0000);
        send_request(FUNC_INSERT, $urandom, $urandom);
        for (i = 0; i <= HEAP_DEPTH; i++)
            send_request(FUNC_EXTRACT, $urandom, $urandom);
        steady = 1'b0;
        wait_all_responses();
    endtask

    // phases of mixed traffic; each starts with a full pause and an order write
    task automatic test_random_mix;
        int phase, len, p_ins, kmode, i;
        t_func f;
        phase = 0;
        while (requests_sent < TARGET_REQUESTS) begin
            wait_all_responses();
            set_order(phase[0]);
            len   = $urandom_range(20, 60);
            kmode = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: p_ins = 35;
                1: p_ins = 50;
                2: p_ins = 70;
                default: p_ins = 85;
            endcase
            steady = (phase == 3);
            for (i = 0; i < len; i++) begin
                f = ($urandom_range(0, 99) < p_ins) ? FUNC_INSERT : FUNC_EXTRACT;
                send_request(f, pick_key(kmode), $urandom);
            end
            phase++;
        end
        steady = 1'b0;
        wait_all_responses();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        held        = 0;
        min_first   = 1'b0;
        steady      = 1'b0;
        requests_sent = 0;
        responses_checked = 0;
        mismatches  = 0;
        n_insert = 0; n_extract = 0; n_full = 0; n_empty = 0;
        order_writes = 0; max_held = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_order(1'b0);
        test_empty_heap();
        test_key_extremes();
        test_equal_keys();
        test_order_switch();
        test_full_heap();
        test_random_mix();

        // let any stray response show up
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests (%0d inserts, %0d extracts), %0d full and %0d empty cases",
                 requests_sent, n_insert, n_extract, n_full, n_empty);
        $display("%0d responses checked over %0d order writes, peak fill %0d, %0d mismatches",
                 responses_checked, order_writes, max_held, mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
